@@ rtl/core/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, status codes,
// widths and the request and response transaction structs. No dependencies.
package rau_pkg;

   localparam int WIDTH = 32;
   localparam int MAG_W = 64;

   localparam logic [2:0] OP_NORM = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_LESS = 3'd5;
   localparam logic [2:0] OP_NEG  = 3'd6;
   localparam logic [2:0] OP_ABS  = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] x_num;
      logic signed [31:0] x_den;
      logic signed [31:0] y_num;
      logic signed [31:0] y_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               is_less;
      logic [1:0]         status;
   } rsp_type;

endpackage

@@ rtl/core/rau_divider.sv @@
// Shared restoring divider of the rational arithmetic unit, one quotient bit
// per cycle on 64-bit magnitudes. Depends on rau_pkg.
module rau_divider
   import rau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] dividend,
   input  logic [MAG_W-1:0] divisor,
   output logic             done,
   output logic [MAG_W-1:0] quotient,
   output logic [MAG_W-1:0] remainder
);

   logic [MAG_W-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [MAG_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 64'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/rational_arithmetic_unit_top.sv @@
// Top level of the rational arithmetic unit: operation sequencer, one 32x32
// multiplier and the shared divider. Depends on rau_pkg and rau_divider.
//
// The unit takes one request transaction (an operation and two fractions) and
// returns one response transaction: a fraction reduced to lowest terms with a
// positive denominator, zero shown as 0/1, or a less-than flag for the compare.
// A zero denominator in a used operand, or a divide by a zero fraction, gives
// status 1 with zero fields; a result outside the numerator or denominator
// range gives status 2. The unit handles one transaction at a time: req_stall
// is high from acceptance until the response has been taken. Every gcd, exact
// quotient and remainder goes through a single restoring divider, and each
// Euclid step or exact divide is one pass of it: the sequencer issues the
// operands, the divider shifts out the quotient bits, and the sequencer takes
// the result. Latency therefore grows with the number of Euclid steps plus
// exact divides. A gcd on 32-bit operands needs at most about 46 steps and the
// final reduction on 64-bit products about 92; the total is data dependent.
// Products use one 32x32 multiplier with a registered result. The response
// sits in an output register and holds while rsp_stall is high.
module rational_arithmetic_unit_top
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Sequencer states.
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LOADX  = 5'd1;
   localparam logic [4:0] S_GCD    = 5'd2;  // a % b steps on ga/gb
   localparam logic [4:0] S_GWAIT  = 5'd3;
   localparam logic [4:0] S_DIVA   = 5'd4;  // exact divides after a gcd
   localparam logic [4:0] S_DIVAW  = 5'd5;
   localparam logic [4:0] S_DIVB   = 5'd6;
   localparam logic [4:0] S_DIVBW  = 5'd7;
   localparam logic [4:0] S_LOADY  = 5'd8;
   localparam logic [4:0] S_DISP   = 5'd9;
   localparam logic [4:0] S_MUL1   = 5'd10;
   localparam logic [4:0] S_MUL2   = 5'd11;
   localparam logic [4:0] S_MUL3   = 5'd12;
   localparam logic [4:0] S_MUL4   = 5'd13;
   localparam logic [4:0] S_COMB   = 5'd14;
   localparam logic [4:0] S_CHECK  = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   // Gcd purposes, telling where to go after the gcd and its divides.
   localparam logic [2:0] G_RX   = 3'd0;  // reduce x
   localparam logic [2:0] G_RY   = 3'd1;  // reduce y
   localparam logic [2:0] G_ADEN = 3'd2;  // gcd of denominators
   localparam logic [2:0] G_M1   = 3'd3;  // x.mag vs y.den
   localparam logic [2:0] G_M2   = 3'd4;  // y.mag vs x.den
   localparam logic [2:0] G_RR   = 3'd5;  // reduce result

   localparam logic [MAG_W-1:0] HALF = MAG_W'(64'd1 << (WIDTH - 1));

   logic [4:0]       state_ff, state_in;
   logic [2:0]       purp_ff, purp_in;
   logic [2:0]       mode_ff, mode_in;
   req_type          req_ff, req_in;
   logic             xn_ff, xn_in, yn_ff, yn_in, rn_ff, rn_in;
   logic [MAG_W-1:0] xm_ff, xm_in, xd_ff, xd_in, ym_ff, ym_in, yd_ff, yd_in;
   logic [MAG_W-1:0] rm_ff, rm_in, rd_ff, rd_in;
   logic [MAG_W-1:0] ga_ff, ga_in, gb_ff, gb_in;   // Euclid pair
   logic [MAG_W-1:0] ta_ff, ta_in, tb_ff, tb_in;   // values to divide by gcd
   logic [MAG_W-1:0] qa_ff, qa_in, qb_ff, qb_in;   // quotients kept
   logic [MAG_W-1:0] prod_ff, prod_in;
   logic [31:0]      mula, mulb;
   logic [MAG_W-1:0] mul_p;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             div_start, div_done;
   logic [MAG_W-1:0] div_a, div_b, div_q, div_r;

   rau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // The single multiplier, shared by all multiply steps.
   assign mul_p = 64'(mula * mulb);

   // Read a WIDTH-bit two's complement word as sign and magnitude.
   function automatic logic [MAG_W:0] read_word(input logic [31:0] raw);
      logic [WIDTH-1:0] v;
      logic [MAG_W-1:0] m;
      v = raw[WIDTH-1:0];
      if (v[WIDTH-1]) begin
         m = MAG_W'((MAG_W+1)'(65'd1 << WIDTH) - (MAG_W+1)'(v));
      end else begin
         m = MAG_W'(v);
      end
      return {v[WIDTH-1], m};
   endfunction

   logic [MAG_W:0] rw_n, rw_d;
   logic           bneg, two;

   always_comb begin
      state_in     = state_ff;
      purp_in      = purp_ff;
      mode_in      = mode_ff;
      req_in       = req_ff;
      xn_in = xn_ff; xm_in = xm_ff; xd_in = xd_ff;
      yn_in = yn_ff; ym_in = ym_ff; yd_in = yd_ff;
      rn_in = rn_ff; rm_in = rm_ff; rd_in = rd_ff;
      ga_in = ga_ff; gb_in = gb_ff; ta_in = ta_ff; tb_in = tb_ff;
      qa_in = qa_ff; qb_in = qb_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_a        = ga_ff;
      div_b        = gb_ff;
      mula         = '0;
      mulb         = '0;
      rw_n         = '0;
      rw_d         = '0;
      bneg         = 1'b0;
      two          = (mode_ff >= OP_ADD) && (mode_ff <= OP_LESS);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               mode_in  = req_data.mode;
               state_in = S_LOADX;
            end
         end
         S_LOADX: begin
            rw_n = read_word(req_ff.x_num);
            rw_d = read_word(req_ff.x_den);
            if (rw_d[MAG_W-1:0] == '0) begin
               rsp_in   = '{res_num: '0, res_den: '0, is_less: 1'b0, status: ST_ZERO};
               state_in = S_OUT;
            end else begin
               xn_in    = rw_n[MAG_W] ^ rw_d[MAG_W];
               ga_in    = rw_n[MAG_W-1:0];
               gb_in    = rw_d[MAG_W-1:0];
               ta_in    = rw_n[MAG_W-1:0];
               tb_in    = rw_d[MAG_W-1:0];
               purp_in  = G_RX;
               state_in = S_GCD;
            end
         end
         S_LOADY: begin
            rw_n = read_word(req_ff.y_num);
            rw_d = read_word(req_ff.y_den);
            if (!two) begin
               state_in = S_DISP;
            end else if (rw_d[MAG_W-1:0] == '0) begin
               rsp_in   = '{res_num: '0, res_den: '0, is_less: 1'b0, status: ST_ZERO};
               state_in = S_OUT;
            end else begin
               yn_in    = rw_n[MAG_W] ^ rw_d[MAG_W];
               ga_in    = rw_n[MAG_W-1:0];
               gb_in    = rw_d[MAG_W-1:0];
               ta_in    = rw_n[MAG_W-1:0];
               tb_in    = rw_d[MAG_W-1:0];
               purp_in  = G_RY;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (gb_ff == '0) begin
               // ga holds the gcd.
               state_in = S_DIVA;
            end else begin
               div_start = 1'b1;
               state_in  = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (div_done) begin
               ga_in    = gb_ff;
               gb_in    = div_r;
               state_in = S_GCD;
            end
         end
         S_DIVA: begin
            if (ga_ff == '0) begin
               // Both zero: values stay as they are.
               qa_in    = ta_ff;
               qb_in    = tb_ff;
               state_in = S_COMB;
            end else begin
               div_start = 1'b1;
               div_a     = ta_ff;
               div_b     = ga_ff;
               state_in  = S_DIVAW;
            end
         end
         S_DIVAW: begin
            if (div_done) begin
               qa_in    = div_q;
               state_in = S_DIVB;
            end
         end
         S_DIVB: begin
            div_start = 1'b1;
            div_a     = tb_ff;
            div_b     = ga_ff;
            state_in  = S_DIVBW;
         end
         S_DIVBW: begin
            if (div_done) begin
               qb_in    = div_q;
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            // Use the gcd and its quotients according to the purpose.
            case (purp_ff)
               G_RX: begin
                  xm_in = qa_ff;
                  xd_in = (qa_ff == '0) ? 64'd1 : qb_ff;
                  if (qa_ff == '0) xn_in = 1'b0;
                  state_in = S_LOADY;
               end
               G_RY: begin
                  ym_in = qa_ff;
                  yd_in = (qa_ff == '0) ? 64'd1 : qb_ff;
                  if (qa_ff == '0) yn_in = 1'b0;
                  state_in = S_DISP;
               end
               G_ADEN: begin
                  // qa = x.den/m, qb = y.den/m.
                  state_in = S_MUL1;
               end
               G_M1: begin
                  // qa = x.mag/m1, qb = y.den/m1; next m2.
                  rm_in    = qa_ff;
                  rd_in    = qb_ff;
                  ga_in    = ym_ff;
                  gb_in    = xd_ff;
                  ta_in    = ym_ff;
                  tb_in    = xd_ff;
                  purp_in  = G_M2;
                  state_in = S_GCD;
               end
               G_M2: begin
                  state_in = S_MUL1;
               end
               default: begin
                  rm_in    = qa_ff;
                  rd_in    = (qa_ff == '0) ? 64'd1 : qb_ff;
                  if (qa_ff == '0) rn_in = 1'b0;
                  state_in = S_CHECK;
               end
            endcase
         end
         S_DISP: begin
            case (mode_ff)
               OP_ADD, OP_SUB: begin
                  ga_in    = xd_ff;
                  gb_in    = yd_ff;
                  ta_in    = xd_ff;
                  tb_in    = yd_ff;
                  purp_in  = G_ADEN;
                  state_in = S_GCD;
               end
               OP_MUL: begin
                  rn_in    = xn_ff ^ yn_ff;
                  ga_in    = xm_ff;
                  gb_in    = yd_ff;
                  ta_in    = xm_ff;
                  tb_in    = yd_ff;
                  purp_in  = G_M1;
                  state_in = S_GCD;
               end
               OP_DIV: begin
                  if (ym_ff == '0) begin
                     rsp_in   = '{res_num: '0, res_den: '0, is_less: 1'b0,
                                  status: ST_ZERO};
                     state_in = S_OUT;
                  end else begin
                     // Multiply by the reciprocal of y.
                     ym_in    = yd_ff;
                     yd_in    = ym_ff;
                     rn_in    = xn_ff ^ yn_ff;
                     ga_in    = xm_ff;
                     gb_in    = ym_ff;
                     ta_in    = xm_ff;
                     tb_in    = ym_ff;
                     purp_in  = G_M1;
                     state_in = S_GCD;
                  end
               end
               OP_LESS: begin
                  state_in = S_MUL1;
               end
               OP_NEG: begin
                  rn_in = (xm_ff != '0) ? !xn_ff : xn_ff;
                  rm_in = xm_ff;
                  rd_in = xd_ff;
                  state_in = S_CHECK;
               end
               OP_ABS: begin
                  rn_in = 1'b0;
                  rm_in = xm_ff;
                  rd_in = xd_ff;
                  state_in = S_CHECK;
               end
               default: begin
                  rn_in = xn_ff;
                  rm_in = xm_ff;
                  rd_in = xd_ff;
                  state_in = S_CHECK;
               end
            endcase
         end
         // Multiplier steps. All factors fit 32 bits: reduced magnitudes
         // stay at most 2^31 and gcd quotients never grow.
         S_MUL1: begin
            case (mode_ff)
               OP_ADD, OP_SUB: begin
                  mula = xm_ff[31:0]; mulb = qb_ff[31:0];  // a
               end
               OP_LESS: begin
                  mula = xm_ff[31:0]; mulb = yd_ff[31:0];  // p
               end
               default: begin
                  mula = rm_ff[31:0]; mulb = qa_ff[31:0];  // magnitude
               end
            endcase
            prod_in  = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            case (mode_ff)
               OP_ADD, OP_SUB: begin
                  mula = ym_ff[31:0]; mulb = qa_ff[31:0];  // b
               end
               OP_LESS: begin
                  mula = ym_ff[31:0]; mulb = xd_ff[31:0];  // q
               end
               default: begin
                  mula = qb_ff[31:0]; mulb = rd_ff[31:0];  // den
               end
            endcase
            ta_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            case (mode_ff)
               OP_ADD, OP_SUB: begin
                  bneg = yn_ff ^ (mode_ff == OP_SUB);
                  if (prod_ff == '0) bneg = 1'b0;
                  if (xn_ff == bneg) begin
                     rn_in = xn_ff;
                     rm_in = ta_ff + prod_ff;
                  end else if (ta_ff >= prod_ff) begin
                     rn_in = xn_ff;
                     rm_in = ta_ff - prod_ff;
                  end else begin
                     rn_in = bneg;
                     rm_in = prod_ff - ta_ff;
                  end
                  state_in = S_MUL4;
               end
               OP_LESS: begin
                  rsp_in.res_num = '0;
                  rsp_in.res_den = 31'd1;
                  rsp_in.status  = ST_OK;
                  if (xn_ff && !yn_ff)      rsp_in.is_less = 1'b1;
                  else if (!xn_ff && yn_ff) rsp_in.is_less = 1'b0;
                  else if (!xn_ff)          rsp_in.is_less = ta_ff < prod_ff;
                  else                      rsp_in.is_less = ta_ff > prod_ff;
                  state_in = S_OUT;
               end
               default: begin
                  rm_in    = ta_ff;
                  rd_in    = prod_ff;
                  ga_in    = ta_ff;
                  gb_in    = prod_ff;
                  tb_in    = prod_ff;
                  purp_in  = G_RR;
                  state_in = S_GCD;
               end
            endcase
         end
         S_MUL4: begin
            // Denominator (x.den/m) * y.den.
            mula     = qa_ff[31:0];
            mulb     = yd_ff[31:0];
            rd_in    = mul_p;
            ga_in    = rm_ff;
            gb_in    = mul_p;
            ta_in    = rm_ff;
            tb_in    = mul_p;
            purp_in  = G_RR;
            state_in = S_GCD;
         end
         S_CHECK: begin
            if ((rd_ff > HALF - 64'd1) ||
                (rn_ff ? (rm_ff > HALF) : (rm_ff > HALF - 64'd1))) begin
               rsp_in = '{res_num: '0, res_den: '0, is_less: 1'b0, status: ST_OVF};
            end else begin
               rsp_in.res_num = rn_ff ? 32'(64'd0 - rm_ff) : rm_ff[31:0];
               rsp_in.res_den = rd_ff[30:0];
               rsp_in.is_less = 1'b0;
               rsp_in.status  = ST_OK;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
            end else if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      xn_ff <= xn_in; xm_ff <= xm_in; xd_ff <= xd_in;
      yn_ff <= yn_in; ym_ff <= ym_in; yd_ff <= yd_in;
      rn_ff <= rn_in; rm_ff <= rm_in; rd_ff <= rd_in;
      ga_ff <= ga_in; gb_ff <= gb_in; ta_ff <= ta_in; tb_ff <= tb_in;
      qa_ff <= qa_in; qb_ff <= qb_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      purp_ff <= purp_in;
      mode_ff <= mode_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A response is only offered from the output state.
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT) else $error("response outside output state");

   // A successful fraction result never has a zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_OK |-> rsp_ff.res_den != '0)
      else $error("zero denominator with ok status");

   // The divider is only started while no transaction is pending at the output.
   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !rsp_valid_ff) else $error("divider started during output");

   // A stalled response stays valid into the next cycle.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("stalled response dropped");

endmodule

@@ tb/tb_rational_arithmetic_unit_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the rational arithmetic unit: directed and random
// fraction operations checked against an exact in-bench predictor.
// Depends on rau_pkg and rational_arithmetic_unit_top.
module tb_rational_arithmetic_unit_top;
   import rau_pkg::*;

   // The unit is slow: each gcd step costs one pass of the divider, so the time
   // per transaction grows with its gcd steps. The watchdog limit covers the
   // slowest transaction plus the longest receiver stall.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int EXP_DEPTH      = 1024;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Expected responses in order of acceptance, as a ring of write and read counts.
   rsp_type expected_rsps [0:EXP_DEPTH-1];
   int      exp_wr_count;
   int      exp_rd_count;
   int      mismatch_count;
   int      idle_cycles;
   bit      timed_out;

   typedef struct {
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
   } fraction_type;

   rational_arithmetic_unit_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gap lengths: mostly zero or short, occasionally long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic fraction_type reduce_fraction(fraction_type f);
      logic [63:0] g;
      g = gcd64(f.mag, f.den);
      if (g != 0) begin
         f.mag = f.mag / g;
         f.den = f.den / g;
      end
      if (f.mag == 0) begin
         f.neg = 1'b0;
         f.den = 1;
      end
      return f;
   endfunction

   // Splits a two's complement word into sign and magnitude.
   function automatic void split_word(logic [31:0] w, output bit neg,
                                      output logic [63:0] mag);
      neg = w[31];
      mag = w[31] ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
   endfunction

   function automatic bit load_fraction(logic [31:0] num, logic [31:0] den,
                                        output fraction_type f);
      bit          nn;
      bit          dn;
      logic [63:0] dm;
      split_word(num, nn, f.mag);
      split_word(den, dn, dm);
      f.neg = nn ^ dn;
      f.den = dm;
      if (dm == 0) return 1'b0;
      f = reduce_fraction(f);
      return 1'b1;
   endfunction

   function automatic fraction_type sum_fraction(fraction_type x, fraction_type y,
                                                 bit sub);
      fraction_type r;
      logic [63:0]  m;
      logic [63:0]  a;
      logic [63:0]  b;
      bit           bn;
      m = gcd64(x.den, y.den);
      a = x.mag * (y.den / m);
      b = y.mag * (x.den / m);
      bn = y.neg ^ sub;
      if (b == 0) bn = 1'b0;
      if (x.neg == bn) begin
         r.neg = x.neg;
         r.mag = a + b;
      end else if (a >= b) begin
         r.neg = x.neg;
         r.mag = a - b;
      end else begin
         r.neg = bn;
         r.mag = b - a;
      end
      r.den = (x.den / m) * y.den;
      return reduce_fraction(r);
   endfunction

   function automatic fraction_type product_fraction(fraction_type x, fraction_type y);
      fraction_type r;
      logic [63:0]  m1;
      logic [63:0]  m2;
      m1 = gcd64(x.mag, y.den);
      m2 = gcd64(y.mag, x.den);
      r.neg = x.neg ^ y.neg;
      r.mag = (x.mag / m1) * (y.mag / m2);
      r.den = (x.den / m2) * (y.den / m1);
      return reduce_fraction(r);
   endfunction

   function automatic bit fraction_less(fraction_type x, fraction_type y);
      logic [63:0] p;
      logic [63:0] q;
      p = x.mag * y.den;
      q = y.mag * x.den;
      if (x.neg && !y.neg) return 1'b1;
      if (!x.neg && y.neg) return 1'b0;
      if (!x.neg) return p < q;
      return p > q;
   endfunction

   // Computes the expected response for one request transaction.
   function automatic rsp_type predict_fraction_op(req_type rq);
      rsp_type      rs;
      fraction_type x;
      fraction_type y;
      fraction_type r;
      fraction_type inv;
      bit           okx;
      bit           oky;
      bit           two;
      logic [63:0]  half;
      half = 64'h8000_0000;
      rs = '0;
      rs.status = ST_OK;
      two = (rq.mode >= OP_ADD) && (rq.mode <= OP_LESS);
      okx = load_fraction(rq.x_num, rq.x_den, x);
      oky = load_fraction(rq.y_num, rq.y_den, y);
      if (!okx || (two && !oky)) begin
         rs.status = ST_ZERO;
         return rs;
      end
      case (rq.mode)
         OP_ADD: r = sum_fraction(x, y, 1'b0);
         OP_SUB: r = sum_fraction(x, y, 1'b1);
         OP_MUL: r = product_fraction(x, y);
         OP_DIV: begin
            if (y.mag == 0) begin
               rs.status = ST_ZERO;
               return rs;
            end
            inv.neg = y.neg;
            inv.mag = y.den;
            inv.den = y.mag;
            r = product_fraction(x, inv);
         end
         OP_LESS: begin
            rs.res_den = 31'd1;
            rs.is_less = fraction_less(x, y);
            return rs;
         end
         OP_NEG: begin
            r = x;
            if (r.mag != 0) r.neg = !r.neg;
         end
         OP_ABS: begin
            r = x;
            r.neg = 1'b0;
         end
         default: r = x;
      endcase
      if (r.den > half - 1 || (r.neg ? (r.mag > half) : (r.mag > half - 1))) begin
         rs.status = ST_OVF;
         return rs;
      end
      rs.res_num = r.neg ? (32'd0 - r.mag[31:0]) : r.mag[31:0];
      rs.res_den = r.den[30:0];
      return rs;
   endfunction

   // Sends one request transaction after a random gap and records its expectation.
   // It returns at the falling edge after acceptance with req_valid still high,
   // so a transaction with no gap follows directly.
   task automatic send_fraction_op(logic [2:0] mode, logic [31:0] xn, logic [31:0] xd,
                                   logic [31:0] yn, logic [31:0] yd);
      req_type rq;
      int      gap;
      rq.mode = mode;
      rq.x_num = xn;
      rq.x_den = xd;
      rq.y_num = yn;
      rq.y_den = yd;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps[exp_wr_count % EXP_DEPTH] = predict_fraction_op(rq);
      exp_wr_count++;
      @(negedge clock);
   endtask

   // Random operand word: a mix of small values, extremes and full-range values.
   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 200) - 100;
      if (r < 6) begin
         case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0001;
            3: return 32'hffff_ffff;
            4: return 32'd1;
            default: return 32'd0;
         endcase
      end
      if (r < 8) return $urandom_range(0, 65535) - 32768;
      return $urandom();
   endfunction

   // Response checker.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr_count == exp_rd_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", rsp_data);
         end else begin
            exp_rsp = expected_rsps[exp_rd_count % EXP_DEPTH];
            exp_rd_count++;
            if (rsp_data.res_num !== exp_rsp.res_num ||
                rsp_data.res_den !== exp_rsp.res_den ||
                rsp_data.is_less !== exp_rsp.is_less ||
                rsp_data.status !== exp_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected num %0d den %0d less %0d st %0d",
                     exp_rsp.res_num, exp_rsp.res_den, exp_rsp.is_less, exp_rsp.status);
                  $display("          actual   num %0d den %0d less %0d st %0d",
                     rsp_data.res_num, rsp_data.res_den, rsp_data.is_less,
                     rsp_data.status);
               end
            end
         end
      end
   end

   // Receiver stall: runs of stall and no stall of random length.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = pick_gap();
         repeat (run) @(negedge clock);
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Watchdog: counts cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_rational_arithmetic_unit_top failed");
         $finish;
      end
   end

   task automatic test_directed_extremes();
      // Every operation, the extremes of both x fields, large y values, zero denominators,
      // a divide by a zero fraction, overflow and ignored second operands.
      send_fraction_op(OP_NORM, 32'd6, -32'd4, 32'd0, 32'd0);
      send_fraction_op(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
      send_fraction_op(OP_NORM, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
      send_fraction_op(OP_NORM, 32'd5, 32'd0, 32'd1, 32'd1);
      send_fraction_op(OP_NORM, 32'd0, -32'd7, 32'd1, 32'd1);
      send_fraction_op(OP_NORM, 32'd3, 32'h8000_0000, 32'd1, 32'd1);
      send_fraction_op(OP_ADD, 32'd1, 32'd6, 32'd1, 32'd10);
      send_fraction_op(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
      send_fraction_op(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
      send_fraction_op(OP_SUB, 32'd1, 32'd3, 32'd1, 32'd3);
      send_fraction_op(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      send_fraction_op(OP_SUB, -32'd1, 32'd2, 32'd1, 32'd3);
      send_fraction_op(OP_MUL, 32'd4, 32'd9, 32'd3, 32'd8);
      send_fraction_op(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
      send_fraction_op(OP_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
      send_fraction_op(OP_DIV, 32'd2, 32'd3, -32'd4, 32'd5);
      send_fraction_op(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5);
      send_fraction_op(OP_DIV, 32'd2, 32'd0, 32'd1, 32'd5);
      send_fraction_op(OP_LESS, -32'd1, 32'd2, 32'd1, 32'd3);
      send_fraction_op(OP_LESS, 32'd1, 32'd3, 32'd1, 32'd3);
      send_fraction_op(OP_LESS, -32'd2, 32'd3, -32'd1, 32'd3);
      send_fraction_op(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
      send_fraction_op(OP_NEG, 32'd0, 32'd5, 32'd0, 32'd0);
      send_fraction_op(OP_ABS, -32'd9, 32'd6, 32'd0, 32'd0);
      send_fraction_op(OP_ABS, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
   endtask

   task automatic test_random_operations(int count);
      logic [31:0] yd;
      for (int i = 0; i < count; i++) begin
         // Zero denominators stay rare so most transactions reach the arithmetic.
         yd = pick_word();
         send_fraction_op(3'($urandom_range(0, 7)), pick_word(), pick_word(),
                          pick_word(), yd);
      end
   endtask

   initial begin
      mismatch_count = 0;
      exp_wr_count = 0;
      exp_rd_count = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_operations(880);
      req_valid <= 1'b0;

      while (exp_wr_count != exp_rd_count) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && exp_wr_count == exp_rd_count)
         $display("tb_rational_arithmetic_unit_top passed");
      else
         $display("tb_rational_arithmetic_unit_top failed");
      $finish;
   end

endmodule

@@ rational_arithmetic_unit_top.f @@
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit_top.sv
tb/tb_rational_arithmetic_unit_top.sv
